@@ hdl/ale_pkg.sv @@
// Shared widths, record layout and command and status codes for the array list engine.
package ale_pkg;

   localparam int CAPACITY = 128;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = 8;
   localparam int CMD_W    = 4;
   localparam int POS_W    = 8;
   localparam int POS2_W   = 7;
   localparam int CODE_W   = 32;
   localparam int YEAR_W   = 16;
   localparam int STATUS_W = 2;
   localparam int REC_W    = CODE_W + YEAR_W;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [YEAR_W-1:0] year;
   } record_type;

   localparam logic [CMD_W-1:0] CMD_INS_FRONT = 4'd0;
   localparam logic [CMD_W-1:0] CMD_INS_AT    = 4'd1;
   localparam logic [CMD_W-1:0] CMD_INS_END   = 4'd2;
   localparam logic [CMD_W-1:0] CMD_REM_FRONT = 4'd3;
   localparam logic [CMD_W-1:0] CMD_REM_AT    = 4'd4;
   localparam logic [CMD_W-1:0] CMD_REM_END   = 4'd5;
   localparam logic [CMD_W-1:0] CMD_SWAP      = 4'd6;
   localparam logic [CMD_W-1:0] CMD_EDIT      = 4'd7;
   localparam logic [CMD_W-1:0] CMD_READ      = 4'd8;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

endpackage

@@ hdl/ale_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module ale_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/array_list_engine.sv @@
// Top level of the array list engine: command decode, shift sequencer and result register.
//
// The block keeps an ordered list of up to 128 records (code and year) in one RAM
// plus an entry count. A command word enters on the req_ channel (valid/ready) and
// exactly one result word leaves on the rsp_ channel (valid/ready).
// A command is taken only while the sequencer is idle; it then touches the RAM one
// entry per cycle over its single read port and single write port. A command
// reads the entries shifted for an insert, the removed entry and those after it
// for a remove, all entries for an edit, two for a swap and one for a read. An
// append writes the new record without reading any entry; rejected and unknown
// commands go straight to the result. The next command can be taken in the cycle
// after the result is registered.
// The result sits in an output register, so the next command is accepted while a
// result still waits; if the receiver stalls, the following result is held inside
// until the output register frees up, and no further command is taken meanwhile.
// Synchronous reset empties the list at once; RAM contents are not cleared and are
// never visible, since only entries below the count are ever read out.
module array_list_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ale_pkg::CMD_W-1:0]            req_cmd,
   input  logic [ale_pkg::POS_W-1:0]            req_position,
   input  logic [ale_pkg::POS2_W-1:0]           req_second_position,
   input  logic signed [ale_pkg::CODE_W-1:0]    req_book_code,
   input  logic signed [ale_pkg::YEAR_W-1:0]    req_book_year,
   input  logic                                 req_edit_field,
   input  logic signed [ale_pkg::CODE_W-1:0]    req_new_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ale_pkg::STATUS_W-1:0]         rsp_status,
   output logic [ale_pkg::CNT_W-1:0]            rsp_entry_total,
   output logic signed [ale_pkg::CODE_W-1:0]    rsp_out_code,
   output logic signed [ale_pkg::YEAR_W-1:0]    rsp_out_year,
   output logic [ale_pkg::CNT_W-1:0]            rsp_edit_matches
);
   import ale_pkg::*;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE,
      OP_SWAP,
      OP_EDIT,
      OP_READ
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_TAIL,
      S_FINISH
   } state_type;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;
   logic [ADDR_W-1:0]     pos2_ff, pos2_in;
   logic [ADDR_W-1:0]     end_ff, end_in;
   logic [ADDR_W-1:0]     rd_addr_ff, rd_addr_in;
   logic                  second_ff, second_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [ADDR_W-1:0]     pend_addr_ff, pend_addr_in;
   logic                  pend_tag_ff, pend_tag_in;
   record_type            new_rec_ff, new_rec_in;
   logic                  field_ff, field_in;
   logic [CODE_W-1:0]     nval_ff, nval_in;
   record_type            hold_ff, hold_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   record_type            res_rec_ff, res_rec_in;
   logic [CNT_W-1:0]      matches_ff, matches_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]      rsp_total_ff, rsp_total_in;
   record_type            rsp_rec_ff, rsp_rec_in;
   logic [CNT_W-1:0]      rsp_matches_ff, rsp_matches_in;

   logic                  req_accept;
   logic [STATUS_W-1:0]   dec_status;
   op_type                dec_op;
   logic [CNT_W-1:0]      dec_pos;
   logic [ADDR_W-1:0]     dec_start;
   logic [ADDR_W-1:0]     dec_end;
   logic [CNT_W-1:0]      dec_count;
   logic [CNT_W-1:0]      count_m1;
   logic                  scan_last;

   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   record_type            ram_wdata;
   logic                  ram_re;
   record_type            ram_rdata;
   logic [REC_W-1:0]      ram_rdata_raw;

   ale_ram #(
      .WIDTH(REC_W),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(rd_addr_ff),
      .rd_data(ram_rdata_raw)
   );

   assign ram_rdata  = record_type'(ram_rdata_raw);
   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign count_m1   = count_ff - CNT_W'(1);

   always_comb begin
      dec_status = ST_OK;
      dec_op     = OP_NONE;
      dec_pos    = '0;
      dec_start  = '0;
      dec_end    = '0;
      dec_count  = count_ff;
      if (req_cmd <= CMD_INS_END) begin
         if (req_cmd == CMD_INS_FRONT) begin
            dec_pos = '0;
         end else if (req_cmd == CMD_INS_END) begin
            dec_pos = count_ff;
         end else begin
            dec_pos = CNT_W'(req_position);
         end
         if (count_ff == CNT_W'(CAPACITY)) begin
            dec_status = ST_FULL;
         end else if (req_cmd == CMD_INS_AT && CNT_W'(req_position) > count_ff) begin
            dec_status = ST_BADPOS;
         end else begin
            dec_op    = OP_INSERT;
            dec_start = count_m1[ADDR_W-1:0];
            dec_end   = dec_pos[ADDR_W-1:0];
            dec_count = count_ff + CNT_W'(1);
         end
      end else if (req_cmd <= CMD_READ) begin
         if (count_ff == '0) begin
            dec_status = ST_EMPTY;
         end else if (req_cmd == CMD_REM_FRONT || req_cmd == CMD_REM_END) begin
            dec_op    = OP_REMOVE;
            dec_pos   = (req_cmd == CMD_REM_FRONT) ? '0 : count_m1;
            dec_start = dec_pos[ADDR_W-1:0];
            dec_end   = count_m1[ADDR_W-1:0];
            dec_count = count_m1;
         end else if (req_cmd == CMD_EDIT) begin
            dec_op    = OP_EDIT;
            dec_start = '0;
            dec_end   = count_m1[ADDR_W-1:0];
         end else if (CNT_W'(req_position) >= count_ff ||
                      (req_cmd == CMD_SWAP && CNT_W'(req_second_position) >= count_ff)) begin
            dec_status = ST_BADPOS;
         end else begin
            dec_pos   = CNT_W'(req_position);
            dec_start = dec_pos[ADDR_W-1:0];
            dec_end   = dec_pos[ADDR_W-1:0];
            if (req_cmd == CMD_REM_AT) begin
               dec_op    = OP_REMOVE;
               dec_end   = count_m1[ADDR_W-1:0];
               dec_count = count_m1;
            end else if (req_cmd == CMD_SWAP) begin
               dec_op = OP_SWAP;
            end else begin
               dec_op = OP_READ;
            end
         end
      end
   end

   always_comb begin
      if (op_ff == OP_SWAP) begin
         scan_last = second_ff;
      end else begin
         scan_last = (rd_addr_ff == end_ff);
      end
   end

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      pos2_in        = pos2_ff;
      end_in         = end_ff;
      rd_addr_in     = rd_addr_ff;
      second_in      = second_ff;
      pend_vld_in    = 1'b0;
      pend_addr_in   = pend_addr_ff;
      pend_tag_in    = pend_tag_ff;
      new_rec_in     = new_rec_ff;
      field_in       = field_ff;
      nval_in        = nval_ff;
      hold_in        = hold_ff;
      res_status_in  = res_status_ff;
      res_rec_in     = res_rec_ff;
      matches_in     = matches_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_rec_in     = rsp_rec_ff;
      rsp_matches_in = rsp_matches_ff;
      ram_we         = 1'b0;
      ram_waddr      = '0;
      ram_wdata      = '0;
      ram_re         = 1'b0;

      // Read data of the previous cycle's access is handled here, whatever the state.
      if (pend_vld_ff) begin
         case (op_ff)
            OP_INSERT: begin
               ram_we    = 1'b1;
               ram_waddr = pend_addr_ff + ADDR_W'(1);
               ram_wdata = ram_rdata;
            end
            OP_REMOVE: begin
               if (pend_addr_ff == pos_ff) begin
                  res_rec_in = ram_rdata;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = pend_addr_ff - ADDR_W'(1);
                  ram_wdata = ram_rdata;
               end
            end
            OP_SWAP: begin
               if (!pend_tag_ff) begin
                  hold_in = ram_rdata;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = pos_ff;
                  ram_wdata = ram_rdata;
               end
            end
            OP_EDIT: begin
               if (ram_rdata.code == new_rec_ff.code) begin
                  ram_we    = 1'b1;
                  ram_waddr = pend_addr_ff;
                  ram_wdata = ram_rdata;
                  if (field_ff) begin
                     ram_wdata.year = nval_ff[YEAR_W-1:0];
                  end else begin
                     ram_wdata.code = nval_ff;
                  end
                  matches_in = matches_ff + CNT_W'(1);
               end
            end
            OP_READ: begin
               res_rec_in = ram_rdata;
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in         = dec_op;
               pos_in        = dec_pos[ADDR_W-1:0];
               pos2_in       = ADDR_W'(req_second_position);
               end_in        = dec_end;
               rd_addr_in    = dec_start;
               second_in     = 1'b0;
               new_rec_in    = '{code: req_book_code, year: req_book_year};
               field_in      = req_edit_field;
               nval_in       = req_new_value;
               res_status_in = dec_status;
               res_rec_in    = '0;
               matches_in    = '0;
               count_in      = dec_count;
               if (dec_op == OP_NONE) begin
                  state_in = S_FINISH;
               end else if (dec_op == OP_INSERT && dec_pos == count_ff) begin
                  state_in = S_TAIL;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            ram_re       = 1'b1;
            pend_vld_in  = 1'b1;
            pend_addr_in = rd_addr_ff;
            pend_tag_in  = second_ff;
            second_in    = 1'b1;
            if (scan_last) begin
               state_in = S_DRAIN;
            end else if (op_ff == OP_INSERT) begin
               rd_addr_in = rd_addr_ff - ADDR_W'(1);
            end else if (op_ff == OP_SWAP) begin
               rd_addr_in = pos2_ff;
            end else begin
               rd_addr_in = rd_addr_ff + ADDR_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_TAIL;
         end
         S_TAIL: begin
            if (op_ff == OP_INSERT) begin
               ram_we    = 1'b1;
               ram_waddr = pos_ff;
               ram_wdata = new_rec_ff;
            end else if (op_ff == OP_SWAP) begin
               ram_we    = 1'b1;
               ram_waddr = pos2_ff;
               ram_wdata = hold_ff;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_total_in   = count_ff;
               rsp_rec_in     = res_rec_ff;
               rsp_matches_in = matches_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      pos_ff         <= pos_in;
      pos2_ff        <= pos2_in;
      end_ff         <= end_in;
      rd_addr_ff     <= rd_addr_in;
      second_ff      <= second_in;
      pend_addr_ff   <= pend_addr_in;
      pend_tag_ff    <= pend_tag_in;
      new_rec_ff     <= new_rec_in;
      field_ff       <= field_in;
      nval_ff        <= nval_in;
      hold_ff        <= hold_in;
      res_status_ff  <= res_status_in;
      res_rec_ff     <= res_rec_in;
      matches_ff     <= matches_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_rec_ff     <= rsp_rec_in;
      rsp_matches_ff <= rsp_matches_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_total  = rsp_total_ff;
   assign rsp_out_code     = rsp_rec_ff.code;
   assign rsp_out_year     = rsp_rec_ff.year;
   assign rsp_edit_matches = rsp_matches_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != rd_addr_ff))
      else $error("read and write of the same entry in one cycle");

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (state_ff == S_SCAN || state_ff == S_DRAIN))
      else $error("read data arrives outside a scan");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |->
         (rsp_rec_ff == '0 && rsp_matches_ff == '0))
      else $error("rejected command returns nonzero data");

   a_append_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_cmd == CMD_INS_END && count_ff != CNT_W'(CAPACITY)) |=>
         (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not grow the list by one");

endmodule
